[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the property holds on every clock edge outside reset.
`define STT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a trigger implies a property on the next clock edge.
`define STT_ASSERT_NEXT(lbl, clk, rst_n, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

[src/stt_pkg.sv]
// ----------------------------------------------------------------------------
// Tokenizer package
// Widths, codes, payload types and helper functions of the tokenizer.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int POS_BITS  = 20;
  localparam int LEN_BITS  = 16;
  localparam int LINE_BITS = 20;

  localparam logic [POS_BITS-1:0]  POS_MAX  = '1;
  localparam logic [LEN_BITS-1:0]  LEN_MAX  = '1;
  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

  typedef enum logic [3:0] {
    M_IDLE, M_OP, M_IDENT, M_INT, M_DOT, M_FRAC, M_STR, M_LCOM, M_BCOM, M_BSTAR,
    M_DEAD
  } mode_e;

  localparam logic [5:0] K_AND   = 6'd19;
  localparam logic [5:0] K_OR    = 6'd20;
  localparam logic [5:0] K_NOT   = 6'd21;
  localparam logic [5:0] K_DIV   = 6'd22;
  localparam logic [5:0] K_EQ    = 6'd23;
  localparam logic [5:0] K_EQEQ  = 6'd24;
  localparam logic [5:0] K_NEQ   = 6'd25;
  localparam logic [5:0] K_PLUS  = 6'd26;
  localparam logic [5:0] K_PP    = 6'd27;
  localparam logic [5:0] K_MINUS = 6'd28;
  localparam logic [5:0] K_MM    = 6'd29;
  localparam logic [5:0] K_MULT  = 6'd30;
  localparam logic [5:0] K_MOD   = 6'd31;
  localparam logic [5:0] K_LP    = 6'd32;
  localparam logic [5:0] K_RP    = 6'd33;
  localparam logic [5:0] K_COMMA = 6'd34;
  localparam logic [5:0] K_COLON = 6'd35;
  localparam logic [5:0] K_DOT   = 6'd36;
  localparam logic [5:0] K_LT    = 6'd37;
  localparam logic [5:0] K_LTE   = 6'd38;
  localparam logic [5:0] K_GT    = 6'd39;
  localparam logic [5:0] K_GTE   = 6'd40;
  localparam logic [5:0] K_STR   = 6'd41;
  localparam logic [5:0] K_ID    = 6'd42;
  localparam logic [5:0] K_INTL  = 6'd43;
  localparam logic [5:0] K_FLT   = 6'd44;
  localparam logic [5:0] K_EOF   = 6'd45;

  localparam logic [2:0] E_CHAR = 3'd0;
  localparam logic [2:0] E_NUM  = 3'd1;
  localparam logic [2:0] E_STR  = 3'd2;
  localparam logic [2:0] E_COM  = 3'd3;
  localparam logic [2:0] E_LONE = 3'd4;

  localparam int NUM_KW = 22;

  localparam logic [55:0] KW_TEXT [NUM_KW] = '{
    56'("int"), 56'("float"), 56'("char"), 56'("string"), 56'("bool"), 56'("if"),
    56'("else"), 56'("end"), 56'("goto"), 56'("when"), 56'("print"),
    56'("endline"), 56'("input"), 56'("finish"), 56'("func"), 56'("void"),
    56'("flag"), 56'("return"), 56'("include"), 56'("AND"), 56'("OR"), 56'("NOT")
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd3, 3'd5, 3'd4, 3'd6, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd4, 3'd5, 3'd7,
    3'd5, 3'd6, 3'd4, 3'd4, 3'd4, 3'd6, 3'd7, 3'd3, 3'd2, 3'd3
  };

  typedef struct packed {
    logic       op;
    logic [7:0] char_byte;
  } in_item_t;

  typedef struct packed {
    logic        is_error;
    logic [5:0]  token_kind;
    logic [2:0]  error_kind;
    logic [19:0] line_number;
    logic [19:0] start_offset;
    logic [15:0] text_length;
    logic        last_of_run;
  } out_item_t;

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      "/":     k = K_DIV;
      "=":     k = K_EQ;
      "!":     k = K_NOT;
      "+":     k = K_PLUS;
      "-":     k = K_MINUS;
      "<":     k = K_LT;
      default: k = K_GT;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] word_kind(logic [55:0] prefix, logic [LEN_BITS-1:0] len);
    logic [5:0] k;
    k = K_ID;
    if (32'(len) <= 32'd7) begin
      for (int i = 0; i < NUM_KW; i++) begin
        if (32'(KW_LEN[i]) == 32'(len) && KW_TEXT[i] == prefix) begin
          k = 6'(i);
        end
      end
    end
    return k;
  endfunction

  function automatic logic [POS_BITS-1:0] pos_inc(logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_BITS'(1);
  endfunction

  function automatic logic [LEN_BITS-1:0] len_inc(logic [LEN_BITS-1:0] v);
    return (v == LEN_MAX) ? v : v + LEN_BITS'(1);
  endfunction

  function automatic logic [LINE_BITS-1:0] line_inc(logic [LINE_BITS-1:0] v);
    return (v == LINE_MAX) ? v : v + LINE_BITS'(1);
  endfunction

  function automatic logic [LINE_BITS-1:0] line_start(logic [15:0] first);
    return (33'(first) > 33'(LINE_MAX)) ? LINE_MAX : LINE_BITS'(first);
  endfunction

  function automatic out_item_t mk_rec(logic err, logic [5:0] kind, logic [2:0] ekind,
                                       logic [LINE_BITS-1:0] line,
                                       logic [POS_BITS-1:0] start,
                                       logic [LEN_BITS-1:0] len);
    out_item_t r;
    r.is_error     = err;
    r.token_kind   = kind;
    r.error_kind   = ekind;
    r.line_number  = 20'(line);
    r.start_offset = 20'(start);
    r.text_length  = 16'(len);
    r.last_of_run  = 1'b0;
    return r;
  endfunction

endpackage

[src/source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexer that turns source bytes into token and error records.
// ----------------------------------------------------------------------------
// One source byte or end marker is accepted per cycle while the output buffer
// has room. Each item yields zero, one or two records, which enter a two-entry
// output buffer; an item is taken whenever that buffer will be empty at the
// clock edge, so the rate of one item per cycle holds while no item produces
// two records and the output is not stalled; after an item that produces two,
// the next waits until one of them has left. The one-byte lookahead for
// two-character operators is held in pend_q, and the whole scanner step is one combinational pass.
`include "assert_macros.svh"

module source_text_tokenizer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  stt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stt_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [15:0]        cfg_data_i
);

  stt_pkg::mode_e                 mode_q, mode_d;
  logic [7:0]                     pend_q, pend_d;
  logic [stt_pkg::POS_BITS-1:0]   start_q, start_d;
  logic [stt_pkg::LEN_BITS-1:0]   len_q, len_d;
  logic [stt_pkg::POS_BITS-1:0]   pos_q, pos_d;
  logic [stt_pkg::LINE_BITS-1:0]  line_q, line_d;
  logic [55:0]                    prefix_q, prefix_d;
  logic [15:0]                    first_q;

  stt_pkg::out_item_t q0_q, q1_q, q0_d, q1_d;
  logic [1:0]         cnt_q, cnt_d;

  stt_pkg::out_item_t p1_rec, p2_rec, r0, r1;
  logic               p1_v, p2_v, do_idle;
  logic [5:0]         op_kind;
  logic               op_hit;
  logic [7:0]         c;
  logic               in_acc, pop, cfg_acc;

  assign c           = in_data_i.char_byte;
  assign pop         = out_valid_o && out_ready_i;
  assign in_ready_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = !in_acc;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = q0_q;

  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    start_d  = start_q;
    len_d    = len_q;
    pos_d    = pos_q;
    line_d   = line_q;
    prefix_d = prefix_q;
    p1_v     = 1'b0;
    p2_v     = 1'b0;
    p1_rec   = '0;
    p2_rec   = '0;
    do_idle  = 1'b0;
    op_kind  = stt_pkg::K_ID;
    op_hit   = 1'b0;

    if (in_data_i.op) begin
      p2_v   = 1'b1;
      p2_rec = stt_pkg::mk_rec(1'b0, stt_pkg::K_EOF, stt_pkg::E_CHAR, line_q, pos_q, '0);
      unique case (mode_q)
        stt_pkg::M_DEAD: p2_v = 1'b0;
        stt_pkg::M_OP: begin
          p1_v = 1'b1;
          if (pend_q == "&" || pend_q == "|") begin
            p1_rec = stt_pkg::mk_rec(1'b1, '0, stt_pkg::E_LONE, line_q, start_q, '0);
            p2_v   = 1'b0;
          end else begin
            p1_rec = stt_pkg::mk_rec(1'b0, stt_pkg::single_kind(pend_q), stt_pkg::E_CHAR,
                                     line_q, start_q, stt_pkg::LEN_BITS'(1));
          end
        end
        stt_pkg::M_IDENT: begin
          p1_v   = 1'b1;
          p1_rec = stt_pkg::mk_rec(1'b0, stt_pkg::word_kind(prefix_q, len_q),
                                   stt_pkg::E_CHAR, line_q, start_q, len_q);
        end
        stt_pkg::M_INT: begin
          p1_v   = 1'b1;
          p1_rec = stt_pkg::mk_rec(1'b0, stt_pkg::K_INTL, stt_pkg::E_CHAR, line_q,
                                   start_q, len_q);
        end
        stt_pkg::M_FRAC: begin
          p1_v   = 1'b1;
          p1_rec = stt_pkg::mk_rec(1'b0, stt_pkg::K_FLT, stt_pkg::E_CHAR, line_q,
                                   start_q, len_q);
        end
        stt_pkg::M_DOT: begin
          p1_v   = 1'b1;
          p2_v   = 1'b0;
          p1_rec = stt_pkg::mk_rec(1'b1, '0, stt_pkg::E_NUM, line_q, start_q, '0);
        end
        stt_pkg::M_STR: begin
          p1_v   = 1'b1;
          p2_v   = 1'b0;
          p1_rec = stt_pkg::mk_rec(1'b1, '0, stt_pkg::E_STR, line_q, start_q, '0);
        end
        stt_pkg::M_BCOM, stt_pkg::M_BSTAR: begin
          p1_v   = 1'b1;
          p2_v   = 1'b0;
          p1_rec = stt_pkg::mk_rec(1'b1, '0, stt_pkg::E_COM, line_q, start_q, '0);
        end
        default: begin
        end
      endcase
      mode_d   = stt_pkg::M_IDLE;
      pend_d   = '0;
      start_d  = '0;
      len_d    = '0;
      pos_d    = '0;
      line_d   = stt_pkg::line_start(first_q);
      prefix_d = '0;
    end else begin
      unique case (mode_q)
        stt_pkg::M_IDLE: do_idle = 1'b1;
        stt_pkg::M_OP: begin
          if (pend_q == "/" && c == "/") begin
            mode_d = stt_pkg::M_LCOM;
          end else if (pend_q == "/" && c == "*") begin
            mode_d = stt_pkg::M_BCOM;
          end else begin
            if (c == "=") begin
              op_hit = 1'b1;
              priority case (pend_q)
                "=":     op_kind = stt_pkg::K_EQEQ;
                "!":     op_kind = stt_pkg::K_NEQ;
                "<":     op_kind = stt_pkg::K_LTE;
                ">":     op_kind = stt_pkg::K_GTE;
                default: op_hit = 1'b0;
              endcase
            end
            if (c == pend_q) begin
              priority case (pend_q)
                "+": begin
                  op_hit  = 1'b1;
                  op_kind = stt_pkg::K_PP;
                end
                "-": begin
                  op_hit  = 1'b1;
                  op_kind = stt_pkg::K_MM;
                end
                "&": begin
                  op_hit  = 1'b1;
                  op_kind = stt_pkg::K_AND;
                end
                "|": begin
                  op_hit  = 1'b1;
                  op_kind = stt_pkg::K_OR;
                end
                default: begin
                end
              endcase
            end
            p1_v = 1'b1;
            if (op_hit) begin
              mode_d = stt_pkg::M_IDLE;
              p1_rec = stt_pkg::mk_rec(1'b0, op_kind, stt_pkg::E_CHAR, line_q, start_q,
                                       stt_pkg::LEN_BITS'(2));
            end else if (pend_q == "&" || pend_q == "|") begin
              mode_d = stt_pkg::M_DEAD;
              p1_rec = stt_pkg::mk_rec(1'b1, '0, stt_pkg::E_LONE, line_q, start_q, '0);
            end else begin
              p1_rec = stt_pkg::mk_rec(1'b0, stt_pkg::single_kind(pend_q), stt_pkg::E_CHAR,
                                       line_q, start_q, stt_pkg::LEN_BITS'(1));
              do_idle = 1'b1;
            end
          end
        end
        stt_pkg::M_IDENT: begin
          if (stt_pkg::is_letter(c) || stt_pkg::is_digit(c)) begin
            if (32'(len_q) < 32'd7) begin
              prefix_d = {prefix_q[47:0], c};
            end
            len_d = stt_pkg::len_inc(len_q);
          end else begin
            p1_v    = 1'b1;
            p1_rec  = stt_pkg::mk_rec(1'b0, stt_pkg::word_kind(prefix_q, len_q),
                                      stt_pkg::E_CHAR, line_q, start_q, len_q);
            do_idle = 1'b1;
          end
        end
        stt_pkg::M_INT: begin
          if (stt_pkg::is_digit(c)) begin
            len_d = stt_pkg::len_inc(len_q);
          end else if (c == ".") begin
            len_d  = stt_pkg::len_inc(len_q);
            mode_d = stt_pkg::M_DOT;
          end else begin
            p1_v    = 1'b1;
            p1_rec  = stt_pkg::mk_rec(1'b0, stt_pkg::K_INTL, stt_pkg::E_CHAR, line_q,
                                      start_q, len_q);
            do_idle = 1'b1;
          end
        end
        stt_pkg::M_DOT: begin
          if (stt_pkg::is_digit(c)) begin
            len_d  = stt_pkg::len_inc(len_q);
            mode_d = stt_pkg::M_FRAC;
          end else begin
            p1_v   = 1'b1;
            mode_d = stt_pkg::M_DEAD;
            p1_rec = stt_pkg::mk_rec(1'b1, '0, stt_pkg::E_NUM, line_q, start_q, '0);
          end
        end
        stt_pkg::M_FRAC: begin
          if (stt_pkg::is_digit(c)) begin
            len_d = stt_pkg::len_inc(len_q);
          end else if (c == ".") begin
            p1_v   = 1'b1;
            mode_d = stt_pkg::M_DEAD;
            p1_rec = stt_pkg::mk_rec(1'b1, '0, stt_pkg::E_NUM, line_q, start_q, '0);
          end else begin
            p1_v    = 1'b1;
            p1_rec  = stt_pkg::mk_rec(1'b0, stt_pkg::K_FLT, stt_pkg::E_CHAR, line_q,
                                      start_q, len_q);
            do_idle = 1'b1;
          end
        end
        stt_pkg::M_STR: begin
          if (c == "\"") begin
            p1_v   = 1'b1;
            mode_d = stt_pkg::M_IDLE;
            p1_rec = stt_pkg::mk_rec(1'b0, stt_pkg::K_STR, stt_pkg::E_CHAR, line_q,
                                     start_q, len_q);
          end else begin
            len_d = stt_pkg::len_inc(len_q);
          end
        end
        stt_pkg::M_LCOM: begin
          if (c == "\n") begin
            line_d = stt_pkg::line_inc(line_q);
            mode_d = stt_pkg::M_IDLE;
          end
        end
        stt_pkg::M_BCOM, stt_pkg::M_BSTAR: begin
          if (mode_q == stt_pkg::M_BSTAR && c == "/") begin
            mode_d = stt_pkg::M_IDLE;
          end else begin
            if (c == "\n") begin
              line_d = stt_pkg::line_inc(line_q);
            end
            mode_d = (c == "*") ? stt_pkg::M_BSTAR : stt_pkg::M_BCOM;
          end
        end
        default: mode_d = stt_pkg::M_DEAD;
      endcase

      if (do_idle) begin
        mode_d  = stt_pkg::M_IDLE;
        start_d = pos_q;
        priority if (c == " ") begin
        end else if (c == "\n") begin
          line_d = stt_pkg::line_inc(line_q);
        end else if (c == "/" || c == "=" || c == "!" || c == "+" || c == "-" ||
                     c == "<" || c == ">" || c == "&" || c == "|") begin
          mode_d = stt_pkg::M_OP;
          pend_d = c;
        end else if (c == "*" || c == "%" || c == "(" || c == ")" || c == "," ||
                     c == ":" || c == ".") begin
          p2_v = 1'b1;
          unique case (c)
            "*":     op_kind = stt_pkg::K_MULT;
            "%":     op_kind = stt_pkg::K_MOD;
            "(":     op_kind = stt_pkg::K_LP;
            ")":     op_kind = stt_pkg::K_RP;
            ",":     op_kind = stt_pkg::K_COMMA;
            ":":     op_kind = stt_pkg::K_COLON;
            default: op_kind = stt_pkg::K_DOT;
          endcase
          p2_rec = stt_pkg::mk_rec(1'b0, op_kind, stt_pkg::E_CHAR, line_q, pos_q,
                                   stt_pkg::LEN_BITS'(1));
        end else if (c == "\"") begin
          mode_d  = stt_pkg::M_STR;
          start_d = stt_pkg::pos_inc(pos_q);
          len_d   = '0;
        end else if (stt_pkg::is_letter(c)) begin
          mode_d   = stt_pkg::M_IDENT;
          prefix_d = {48'b0, c};
          len_d    = stt_pkg::LEN_BITS'(1);
        end else if (stt_pkg::is_digit(c)) begin
          mode_d = stt_pkg::M_INT;
          len_d  = stt_pkg::LEN_BITS'(1);
        end else begin
          mode_d = stt_pkg::M_DEAD;
          p2_v   = 1'b1;
          p2_rec = stt_pkg::mk_rec(1'b1, '0, stt_pkg::E_CHAR, line_q, pos_q, '0);
        end
      end
      pos_d = stt_pkg::pos_inc(pos_q);
    end

    r0 = p1_v ? p1_rec : p2_rec;
    r1 = p2_rec;
    if (p1_v && p2_v) begin
      r1.last_of_run = 1'b1;
    end else begin
      r0.last_of_run = 1'b1;
    end
  end

  always_comb begin
    q0_d  = pop ? q1_q : q0_q;
    q1_d  = q1_q;
    cnt_d = cnt_q - {1'b0, pop};
    if (in_acc) begin
      q0_d  = r0;
      q1_d  = r1;
      cnt_d = 2'({1'b0, p1_v} + {1'b0, p2_v});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= stt_pkg::M_IDLE;
      pend_q   <= '0;
      start_q  <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      line_q   <= stt_pkg::line_start(16'd1);
      prefix_q <= '0;
      first_q  <= 16'd1;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_acc) begin
        mode_q   <= mode_d;
        pend_q   <= pend_d;
        start_q  <= start_d;
        len_q    <= len_d;
        pos_q    <= pos_d;
        line_q   <= line_d;
        prefix_q <= prefix_d;
      end else if (cfg_acc) begin
        first_q <= cfg_data_i;
        if (pos_q == '0 && mode_q == stt_pkg::M_IDLE) begin
          line_q <= stt_pkg::line_start(cfg_data_i);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q0_q <= q0_d;
    q1_q <= q1_d;
  end

  `STT_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "output buffer overflow")
  `STT_ASSERT(a_ready_room, clk_i, rst_ni, !in_ready_o || cnt_q != 2'd2,
              "item accepted into a full buffer")
  `STT_ASSERT_NEXT(a_dead_drop, clk_i, rst_ni,
                   in_acc && !in_data_i.op && mode_q == stt_pkg::M_DEAD,
                   mode_q == stt_pkg::M_DEAD && cnt_q == 2'd0,
                   "byte after an error produced a record")

endmodule

[bench/tb_source_text_tokenizer.sv]
// ----------------------------------------------------------------------------
// Tokenizer testbench
// Drives byte streams and end markers into the tokenizer, predicts the
// token and error records in a scanner model of its own (a few directed
// ones are typed in), and compares each record field by field. Sources are
// mostly well-formed token sequences with random content, mixed with noise
// bytes and broken endings. Both sides idle in random bursts, and the first
// line register is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_source_text_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    stt_pkg::in_item_t  item;
    bit                 typed;
    stt_pkg::out_item_t rec;
  } row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  stt_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  stt_pkg::out_item_t out_data_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [15:0]        cfg_data_i = '0;

  source_text_tokenizer DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  string keywords [22] = '{"int", "float", "char", "string", "bool", "if", "else", "end",
    "goto", "when", "print", "endline", "input", "finish", "func", "void", "flag",
    "return", "include", "AND", "OR", "NOT"};
  string operators [22] = '{"/", "=", "==", "!=", "+", "++", "-", "--", "*", "%", "(",
    ")", ",", ":", ".", "<", "<=", ">", ">=", "&&", "||", "!"};

  // Scanner state of the prediction.
  stt_pkg::mode_e      s_mode;
  logic [7:0]          s_pend;
  logic [19:0]         s_start, s_pos, s_line;
  logic [15:0]         s_len, s_first;
  logic [55:0]         s_word;
  stt_pkg::out_item_t  step_recs[$];
  stt_pkg::out_item_t  awaited_records[$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  int  stall_left = 0;

  function automatic bit letter_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [19:0] inc20(logic [19:0] v);
    return (v == '1) ? v : v + 20'd1;
  endfunction

  function automatic logic [15:0] inc16(logic [15:0] v);
    return (v == '1) ? v : v + 16'd1;
  endfunction

  function automatic void add_rec(bit err, logic [5:0] kind, logic [2:0] ek,
                                  logic [19:0] start, logic [15:0] len);
    stt_pkg::out_item_t r;
    r.is_error = err;
    r.token_kind = kind;
    r.error_kind = ek;
    r.line_number = s_line;
    r.start_offset = start;
    r.text_length = len;
    r.last_of_run = 1'b0;
    step_recs = {step_recs, r};
  endfunction

  function automatic void add_fault(logic [2:0] ek);
    s_mode = stt_pkg::M_DEAD;
    add_rec(1'b1, 6'd0, ek, s_start, 16'd0);
  endfunction

  function automatic logic [5:0] word_code();
    logic [55:0] packed_kw;
    if (s_len > 16'd7) return stt_pkg::K_ID;
    for (int i = 0; i < 22; i++) begin
      packed_kw = '0;
      for (int n = 0; n < keywords[i].len(); n++) packed_kw = {packed_kw[47:0], keywords[i][n]};
      if (keywords[i].len() == s_len && packed_kw == s_word) return 6'(i);
    end
    return stt_pkg::K_ID;
  endfunction

  function automatic logic [5:0] single_code(logic [7:0] c);
    case (c)
      "/": return stt_pkg::K_DIV;
      "=": return stt_pkg::K_EQ;
      "!": return stt_pkg::K_NOT;
      "+": return stt_pkg::K_PLUS;
      "-": return stt_pkg::K_MINUS;
      "<": return stt_pkg::K_LT;
      default: return stt_pkg::K_GT;
    endcase
  endfunction

  function automatic void idle_char(logic [7:0] c, logic [19:0] p);
    s_mode = stt_pkg::M_IDLE;
    s_start = p;
    case (c)
      " ": ;
      "\n": s_line = inc20(s_line);
      "/", "=", "!", "+", "-", "<", ">", "&", "|": begin
        s_mode = stt_pkg::M_OP;
        s_pend = c;
      end
      "*": add_rec(1'b0, stt_pkg::K_MULT, stt_pkg::E_CHAR, p, 16'd1);
      "%": add_rec(1'b0, stt_pkg::K_MOD, stt_pkg::E_CHAR, p, 16'd1);
      "(": add_rec(1'b0, stt_pkg::K_LP, stt_pkg::E_CHAR, p, 16'd1);
      ")": add_rec(1'b0, stt_pkg::K_RP, stt_pkg::E_CHAR, p, 16'd1);
      ",": add_rec(1'b0, stt_pkg::K_COMMA, stt_pkg::E_CHAR, p, 16'd1);
      ":": add_rec(1'b0, stt_pkg::K_COLON, stt_pkg::E_CHAR, p, 16'd1);
      ".": add_rec(1'b0, stt_pkg::K_DOT, stt_pkg::E_CHAR, p, 16'd1);
      "\"": begin
        s_mode = stt_pkg::M_STR;
        s_start = inc20(p);
        s_len = '0;
      end
      default: begin
        if (letter_ch(c)) begin
          s_mode = stt_pkg::M_IDENT;
          s_word = {48'd0, c};
          s_len = 16'd1;
        end else if (digit_ch(c)) begin
          s_mode = stt_pkg::M_INT;
          s_len = 16'd1;
        end else begin
          add_fault(stt_pkg::E_CHAR);
        end
      end
    endcase
  endfunction

  function automatic void op_char(logic [7:0] c, logic [19:0] p);
    int kind;
    kind = -1;
    if (s_pend == "/" && c == "/") begin
      s_mode = stt_pkg::M_LCOM;
      return;
    end
    if (s_pend == "/" && c == "*") begin
      s_mode = stt_pkg::M_BCOM;
      return;
    end
    if (c == "=") begin
      if (s_pend == "=") kind = stt_pkg::K_EQEQ;
      else if (s_pend == "!") kind = stt_pkg::K_NEQ;
      else if (s_pend == "<") kind = stt_pkg::K_LTE;
      else if (s_pend == ">") kind = stt_pkg::K_GTE;
    end
    if (c == s_pend) begin
      if (s_pend == "+") kind = stt_pkg::K_PP;
      else if (s_pend == "-") kind = stt_pkg::K_MM;
      else if (s_pend == "&") kind = stt_pkg::K_AND;
      else if (s_pend == "|") kind = stt_pkg::K_OR;
    end
    if (kind >= 0) begin
      s_mode = stt_pkg::M_IDLE;
      add_rec(1'b0, 6'(kind), stt_pkg::E_CHAR, s_start, 16'd2);
    end else if (s_pend == "&" || s_pend == "|") begin
      add_fault(stt_pkg::E_LONE);
    end else begin
      add_rec(1'b0, single_code(s_pend), stt_pkg::E_CHAR, s_start, 16'd1);
      idle_char(c, p);
    end
  endfunction

  function automatic void restart_scan();
    s_mode = stt_pkg::M_IDLE;
    s_pend = '0;
    s_start = '0;
    s_len = '0;
    s_pos = '0;
    s_line = 20'(s_first);
    s_word = '0;
  endfunction

  function automatic void load_first_line(logic [15:0] v);
    s_first = v;
    if (s_pos == '0 && s_mode == stt_pkg::M_IDLE) s_line = 20'(v);
  endfunction

  function automatic void scan_item(stt_pkg::in_item_t it);
    logic [7:0] c;
    bit ended;
    c = it.char_byte;
    step_recs = {};
    if (it.op) begin
      ended = 1'b0;
      case (s_mode)
        stt_pkg::M_DEAD: ended = 1'b1;
        stt_pkg::M_OP: begin
          if (s_pend == "&" || s_pend == "|") begin
            add_fault(stt_pkg::E_LONE);
            ended = 1'b1;
          end else begin
            add_rec(1'b0, single_code(s_pend), stt_pkg::E_CHAR, s_start, 16'd1);
          end
        end
        stt_pkg::M_IDENT: add_rec(1'b0, word_code(), stt_pkg::E_CHAR, s_start, s_len);
        stt_pkg::M_INT: add_rec(1'b0, stt_pkg::K_INTL, stt_pkg::E_CHAR, s_start, s_len);
        stt_pkg::M_FRAC: add_rec(1'b0, stt_pkg::K_FLT, stt_pkg::E_CHAR, s_start, s_len);
        stt_pkg::M_DOT: begin
          add_fault(stt_pkg::E_NUM);
          ended = 1'b1;
        end
        stt_pkg::M_STR: begin
          add_fault(stt_pkg::E_STR);
          ended = 1'b1;
        end
        stt_pkg::M_BCOM, stt_pkg::M_BSTAR: begin
          add_fault(stt_pkg::E_COM);
          ended = 1'b1;
        end
        default: ;
      endcase
      if (!ended) add_rec(1'b0, stt_pkg::K_EOF, stt_pkg::E_CHAR, s_pos, 16'd0);
      restart_scan();
    end else begin
      case (s_mode)
        stt_pkg::M_IDLE: idle_char(c, s_pos);
        stt_pkg::M_OP: op_char(c, s_pos);
        stt_pkg::M_IDENT: begin
          if (letter_ch(c) || digit_ch(c)) begin
            if (s_len < 16'd7) s_word = {s_word[47:0], c};
            s_len = inc16(s_len);
          end else begin
            add_rec(1'b0, word_code(), stt_pkg::E_CHAR, s_start, s_len);
            idle_char(c, s_pos);
          end
        end
        stt_pkg::M_INT: begin
          if (digit_ch(c)) begin
            s_len = inc16(s_len);
          end else if (c == ".") begin
            s_len = inc16(s_len);
            s_mode = stt_pkg::M_DOT;
          end else begin
            add_rec(1'b0, stt_pkg::K_INTL, stt_pkg::E_CHAR, s_start, s_len);
            idle_char(c, s_pos);
          end
        end
        stt_pkg::M_DOT: begin
          if (digit_ch(c)) begin
            s_len = inc16(s_len);
            s_mode = stt_pkg::M_FRAC;
          end else begin
            add_fault(stt_pkg::E_NUM);
          end
        end
        stt_pkg::M_FRAC: begin
          if (digit_ch(c)) begin
            s_len = inc16(s_len);
          end else if (c == ".") begin
            add_fault(stt_pkg::E_NUM);
          end else begin
            add_rec(1'b0, stt_pkg::K_FLT, stt_pkg::E_CHAR, s_start, s_len);
            idle_char(c, s_pos);
          end
        end
        stt_pkg::M_STR: begin
          if (c == "\"") begin
            add_rec(1'b0, stt_pkg::K_STR, stt_pkg::E_CHAR, s_start, s_len);
            s_mode = stt_pkg::M_IDLE;
          end else begin
            s_len = inc16(s_len);
          end
        end
        stt_pkg::M_LCOM: begin
          if (c == "\n") begin
            s_line = inc20(s_line);
            s_mode = stt_pkg::M_IDLE;
          end
        end
        stt_pkg::M_BCOM, stt_pkg::M_BSTAR: begin
          if (s_mode == stt_pkg::M_BSTAR && c == "/") begin
            s_mode = stt_pkg::M_IDLE;
          end else begin
            if (c == "\n") s_line = inc20(s_line);
            s_mode = (c == "*") ? stt_pkg::M_BSTAR : stt_pkg::M_BCOM;
          end
        end
        default: s_mode = stt_pkg::M_DEAD;
      endcase
      s_pos = inc20(s_pos);
    end
    if (step_recs.size() > 0) step_recs[step_recs.size()-1].last_of_run = 1'b1;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Result side: comparison, random stalls and the watchdog.
  always @(posedge clk_i) begin
    stt_pkg::out_item_t want;
    logic next_ready;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= 2000) begin
        $display("FAIL");
        $finish;
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_records.size() == 0) begin
          $error("record with no expectation: %p", out_data_o);
          fail_count++;
        end else begin
          want = awaited_records.pop_front();
          check_field("is_error", want.is_error, out_data_o.is_error);
          check_field("token_kind", want.token_kind, out_data_o.token_kind);
          check_field("error_kind", want.error_kind, out_data_o.error_kind);
          check_field("line_number", want.line_number, out_data_o.line_number);
          check_field("start_offset", want.start_offset, out_data_o.start_offset);
          check_field("text_length", want.text_length, out_data_o.text_length);
          check_field("last_of_run", want.last_of_run, out_data_o.last_of_run);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      next_ready = 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 9);
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    out_ready_i <= next_ready;
  end

  task automatic send_item(row_t r);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r.item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    scan_item(r.item);
    if (r.typed) awaited_records = {awaited_records, r.rec};
    else awaited_records = {awaited_records, step_recs};
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (awaited_records.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_first_line(logic [15:0] v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    load_first_line(v);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic row_t byte_row(logic [7:0] c);
    row_t r;
    r.item.op = 1'b0;
    r.item.char_byte = c;
    r.typed = 1'b0;
    r.rec = '0;
    return r;
  endfunction

  function automatic row_t end_row();
    row_t r;
    r = byte_row(8'($urandom_range(0, 255)));
    r.item.op = 1'b1;
    return r;
  endfunction

  function automatic void add_text(ref row_t q[$], input string s);
    for (int i = 0; i < s.len(); i++) q = {q, byte_row(s[i])};
  endfunction

  function automatic string rand_word(int n, bit start_digit);
    string s;
    string pool;
    s = "";
    pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
    for (int i = 0; i < n; i++) begin
      if (i == 0 && !start_digit) s = {s, pool.substr(0, 0)};
      s = {s, pool.substr(0, 0)};
      s[s.len()-1] = start_digit ? 8'("0" + $urandom_range(0, 9))
                                 : pool[$urandom_range(0, (i == 0) ? 52 : 62)];
      if (i == 0 && !start_digit) s = s.substr(1, s.len() - 1);
    end
    return s;
  endfunction

  function automatic void add_source(ref row_t q[$]);
    int n;
    string inner;
    n = $urandom_range(1, 8);
    for (int t = 0; t < n; t++) begin
      case ($urandom_range(0, 11))
        0: add_text(q, keywords[$urandom_range(0, 21)]);
        1: add_text(q, rand_word($urandom_range(1, 10), 1'b0));
        2: add_text(q, rand_word($urandom_range(1, 5), 1'b1));
        3: add_text(q, {rand_word($urandom_range(1, 3), 1'b1), ".",
                        rand_word($urandom_range(1, 3), 1'b1)});
        4: begin
          inner = rand_word($urandom_range(0, 6), 1'b0);
          if ($urandom_range(0, 2) == 0) inner = {inner, "\n *"};
          add_text(q, {"\"", inner, "\""});
        end
        5: add_text(q, {"//", rand_word($urandom_range(0, 5), 1'b0), "\n"});
        6: add_text(q, {"/*", rand_word($urandom_range(0, 3), 1'b0), "*\n**/"});
        7: add_text(q, operators[$urandom_range(0, 21)]);
        8: add_text(q, ($urandom_range(0, 1) == 0) ? " " : "\n");
        9: q = {q, byte_row(8'($urandom_range(0, 255)))};
        default: add_text(q, keywords[$urandom_range(0, 21)]);
      endcase
      case ($urandom_range(0, 3))
        0: add_text(q, "\n");
        1, 2: add_text(q, " ");
        default: ;
      endcase
    end
    case ($urandom_range(0, 15))
      0: add_text(q, "\"ab");
      1: add_text(q, "/*x*");
      2: add_text(q, "7.");
      3: add_text(q, "&");
      4: add_text(q, "1.2.3");
      5: add_text(q, "|");
      default: ;
    endcase
    q = {q, end_row()};
  endfunction

  initial begin
    row_t rows[$];
    row_t r;
    int sent;
    int since_write;
    int step_no;
    logic [15:0] line_values [5];

    s_first = 16'd1;
    restart_scan();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: a few records typed in, then short sources.
    r = byte_row("*");
    r.typed = 1'b1;
    r.rec = '{1'b0, stt_pkg::K_MULT, stt_pkg::E_CHAR, 20'd1, 20'd0, 16'd1, 1'b1};
    rows = {rows, r};
    r = byte_row(8'hFF);
    r.typed = 1'b1;
    r.rec = '{1'b1, 6'd0, stt_pkg::E_CHAR, 20'd1, 20'd1, 16'd0, 1'b1};
    rows = {rows, r};
    rows = {rows, end_row()};
    r = end_row();
    r.typed = 1'b1;
    r.rec = '{1'b0, stt_pkg::K_EOF, stt_pkg::E_CHAR, 20'd1, 20'd0, 16'd0, 1'b1};
    rows = {rows, r};
    add_text(rows, "endline 1.5--!=&|x");
    rows = {rows, end_row()};
    add_text(rows, "\"a\nb\"/*");
    rows = {rows, end_row()};
    foreach (rows[i]) send_item(rows[i]);

    line_values = '{16'd0, 16'hFFFF, 16'($urandom_range(2, 65534)), 16'd7, 16'd1};
    sent = 0;
    since_write = 0;
    step_no = 0;
    write_first_line(line_values[0]);
    step_no = 1;
    while (sent < 1300) begin
      rows = {};
      add_source(rows);
      foreach (rows[i]) send_item(rows[i]);
      sent += rows.size();
      since_write += rows.size();
      if (sent > 1100) calm = 1'b1;
      if (since_write >= 250 && step_no < 5) begin
        write_first_line(line_values[step_no]);
        step_no++;
        since_write = 0;
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

[filelist.f]
+incdir+src
src/stt_pkg.sv
src/source_text_tokenizer.sv
bench/tb_source_text_tokenizer.sv
